// ----- rtl/cts_pkg.sv -----
// Shared types, mode codes and calendar helpers for the clock time-set editor.
// Used by cts_update, clock_time_set_editor and cts_checker; depends on nothing.

package cts_pkg;

    // Item modes carried on the input tuser
    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_TOGGLE = 3'd1;
    localparam logic [2:0] MODE_NEXT   = 3'd2;
    localparam logic [2:0] MODE_INC    = 3'd3;
    localparam logic [2:0] MODE_DEC    = 3'd4;
    localparam logic [2:0] MODE_TICK   = 3'd5;

    // Field selector codes
    localparam logic [2:0] SEL_YEAR   = 3'd0;
    localparam logic [2:0] SEL_MONTH  = 3'd1;
    localparam logic [2:0] SEL_DATE   = 3'd2;
    localparam logic [2:0] SEL_HOUR   = 3'd3;
    localparam logic [2:0] SEL_MINUTE = 3'd4;
    localparam logic [2:0] SEL_SECOND = 3'd5;

    // Field limits
    localparam logic [6:0] YEAR_MAX  = 7'd99;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [5:0] MIN_MAX   = 6'd59;

    // Register map
    localparam int         DATA_W           = 32;
    localparam int         ADDR_W           = 2;
    localparam logic [1:0] ADDR_BLINK_PERIOD = 2'd0;
    localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

    // Packed beat widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cts_time_t;

    typedef struct packed {
        cts_time_t   tm;
        logic [2:0]  field_sel;
        logic        edit;
        logic        blink;
        logic [15:0] tick_count;
    } cts_state_t;

    // Editor state after reset: 00-01-01 00:00:00, not editing
    localparam cts_state_t STATE_RST = '{
        tm: '{year: 7'd0, month: 4'd1, date: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0},
        field_sel: SEL_YEAR,
        edit: 1'b0,
        blink: 1'b0,
        tick_count: 16'd0
    };

    // Days in a month; a year divisible by 4 is a leap year, bad months count as 31
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        begin
            case (month) inside
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                4'd2:                    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ----- rtl/clock_time_set_editor.sv -----
// Clock time-set editor: an accepted input beat reaches its result beat through the input register,
// then the update and the result register.
// Throughput: one beat per cycle while the result stream does not stall; the state update is combinational.
// The input stage refills while a result waits, so one beat buffers during a stall.
// Reset (aresetn low, synchronous): time 00-01-01 00:00:00, not editing, blink phase 0,
// tick count 0, blink period 500, both stages empty.

module clock_time_set_editor import cts_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [6:0] load_year, [10:7] load_month, [15:11] load_date, [20:16] load_hour,
    // [26:21] load_minute, [32:27] load_second, [39:33] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]           s_axis_tuser,
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [6:0] year_out, [10:7] month_out, [15:11] date_out, [20:16] hour_out,
    // [26:21] minute_out, [32:27] second_out, [35:33] selected_field, [36] editing,
    // [37] blink_phase, [38] commit, [39] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // Configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    logic            in_valid_reg;
    logic [2:0]      in_mode_reg;
    cts_time_t       in_load_reg;
    cts_state_t      state_reg;
    cts_state_t      state_next;
    logic            commit;
    logic            out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [15:0]     blink_period_reg;
    logic            advance;
    logic            cfg_write;
    cts_time_t       s_load;

    // Pipeline control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Unpack the load fields of the input beat
    assign s_load.year   = s_axis_tdata[6:0];
    assign s_load.month  = s_axis_tdata[10:7];
    assign s_load.date   = s_axis_tdata[15:11];
    assign s_load.hour   = s_axis_tdata[20:16];
    assign s_load.minute = s_axis_tdata[26:21];
    assign s_load.second = s_axis_tdata[32:27];

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BLINK_PERIOD);
    assign prdata    = (paddr == ADDR_BLINK_PERIOD) ? {{(DATA_W-16){1'b0}}, blink_period_reg}
                                                    : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg <= BLINK_PERIOD_RST;
        end else if (cfg_write) begin
            blink_period_reg <= pwdata[15:0];
        end
    end

    // Input register: hold the beat until the update stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_mode_reg <= s_axis_tuser;
            in_load_reg <= s_load;
        end
    end

    cts_update u_update (
        .state_cur    (state_reg),
        .mode         (in_mode_reg),
        .load_tm      (in_load_reg),
        .blink_period (blink_period_reg),
        .state_nxt    (state_next),
        .commit       (commit)
    );

    // Editor state: advance once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RST;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, commit, state_next.blink, state_next.edit,
                             state_next.field_sel, state_next.tm.second, state_next.tm.minute,
                             state_next.tm.hour, state_next.tm.date, state_next.tm.month,
                             state_next.tm.year};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- rtl/cts_update.sv -----
// Next-state logic of the clock time-set editor for one beat.
// Depends on cts_pkg (state types, mode codes, month_len).

module cts_update import cts_pkg::*; (
    input  cts_state_t  state_cur,
    input  logic [2:0]  mode,
    input  cts_time_t   load_tm,
    input  logic [15:0] blink_period,
    output cts_state_t  state_nxt,
    output logic        commit
);

    cts_time_t   tm_inc;
    cts_time_t   tm_dec;
    logic [4:0]  len_cur;
    logic [4:0]  len_inc;
    logic [4:0]  len_dec;
    logic [16:0] tick_sum;

    assign len_cur = month_len(state_cur.tm.month, state_cur.tm.year);

    // Increment the selected field, then wrap every field into range
    always_comb begin
        tm_inc = state_cur.tm;
        case (state_cur.field_sel)
            SEL_YEAR:   tm_inc.year   = state_cur.tm.year + 7'd1;
            SEL_MONTH:  tm_inc.month  = state_cur.tm.month + 4'd1;
            SEL_DATE:   tm_inc.date   = state_cur.tm.date + 5'd1;
            SEL_HOUR:   tm_inc.hour   = state_cur.tm.hour + 5'd1;
            SEL_MINUTE: tm_inc.minute = state_cur.tm.minute + 6'd1;
            SEL_SECOND: tm_inc.second = state_cur.tm.second + 6'd1;
            default: ;
        endcase
        if (tm_inc.year > YEAR_MAX) tm_inc.year = '0;
        if (tm_inc.month > MONTH_MAX) tm_inc.month = 4'd1;
        len_inc = month_len(tm_inc.month, tm_inc.year);
        if (tm_inc.date > len_inc) tm_inc.date = 5'd1;
        if (tm_inc.hour > HOUR_MAX) tm_inc.hour = '0;
        if (tm_inc.minute > MIN_MAX) tm_inc.minute = '0;
        if (tm_inc.second > MIN_MAX) tm_inc.second = '0;
    end

    // Decrement the selected field with wrap, then fix the date against the month
    always_comb begin
        tm_dec = state_cur.tm;
        case (state_cur.field_sel)
            SEL_YEAR: begin
                tm_dec.year = (state_cur.tm.year == 7'd0) ? YEAR_MAX : state_cur.tm.year - 7'd1;
            end
            SEL_MONTH: begin
                tm_dec.month = (state_cur.tm.month <= 4'd1) ? MONTH_MAX
                                                            : state_cur.tm.month - 4'd1;
            end
            SEL_DATE: begin
                tm_dec.date = (state_cur.tm.date <= 5'd1) ? len_cur : state_cur.tm.date - 5'd1;
            end
            SEL_HOUR: begin
                tm_dec.hour = (state_cur.tm.hour == 5'd0) ? HOUR_MAX : state_cur.tm.hour - 5'd1;
            end
            SEL_MINUTE: begin
                tm_dec.minute = (state_cur.tm.minute == 6'd0) ? MIN_MAX
                                                              : state_cur.tm.minute - 6'd1;
            end
            SEL_SECOND: begin
                tm_dec.second = (state_cur.tm.second == 6'd0) ? MIN_MAX
                                                              : state_cur.tm.second - 6'd1;
            end
            default: ;
        endcase
        len_dec = month_len(tm_dec.month, tm_dec.year);
        if (tm_dec.date == 5'd0) tm_dec.date = len_dec;
        else if (tm_dec.date > len_dec) tm_dec.date = 5'd1;
    end

    assign tick_sum = {1'b0, state_cur.tick_count} + 17'd1;

    // Select the update by mode
    always_comb begin
        state_nxt = state_cur;
        commit    = 1'b0;
        case (mode)
            MODE_LOAD: begin
                state_nxt.tm = load_tm;
            end
            MODE_TOGGLE: begin
                if (!state_cur.edit) begin
                    state_nxt.edit      = 1'b1;
                    state_nxt.field_sel = SEL_YEAR;
                end else begin
                    state_nxt.edit = 1'b0;
                    commit         = 1'b1;
                end
            end
            MODE_NEXT: begin
                if (state_cur.edit) begin
                    state_nxt.field_sel = (state_cur.field_sel >= SEL_SECOND) ? SEL_YEAR
                                          : state_cur.field_sel + 3'd1;
                end
            end
            MODE_INC: begin
                if (state_cur.edit) state_nxt.tm = tm_inc;
            end
            MODE_DEC: begin
                if (state_cur.edit) state_nxt.tm = tm_dec;
            end
            MODE_TICK: begin
                if (tick_sum >= {1'b0, blink_period}) begin
                    state_nxt.tick_count = '0;
                    state_nxt.blink      = ~state_cur.blink;
                end else begin
                    state_nxt.tick_count = tick_sum[15:0];
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/cts_checker.sv -----
// Port-level checks for clock_time_set_editor, attached by the bind below.
// Depends on cts_pkg for widths and selector codes.

module cts_checker import cts_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // No result beat right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Commit only on a beat that leaves edit mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[38] && m_axis_tdata[36]))
        else $error("commit while still editing");

    // Selector stays in the field range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[35:33] <= SEL_SECOND))
        else $error("selector out of range");

    // Padding bit stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[39])
        else $error("padding bit set");

endmodule

bind clock_time_set_editor cts_checker u_cts_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
